// ===== rtl/core/spi9_pkg.sv =====
// spi9_pkg: shared types and constants for the 3-wire 9-bit serial sender
// used by spi9_seq and three_wire_nine_bit_spi_sender; no dependencies
package spi9_pkg;

    localparam int DATA_BITS  = 8;
    localparam int WORD_BITS  = DATA_BITS + 1;
    localparam int HOLD_W     = 8;
    localparam int BIT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_HOLD    = 1'd1;

    localparam logic [HOLD_W-1:0] HALF_PERIOD_RESET = 8'd8;
    localparam logic [HOLD_W-1:0] END_HOLD_RESET    = 8'd12;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_LEAD     = 6'b000010,
        PH_BIT_LOW  = 6'b000100,
        PH_BIT_HIGH = 6'b001000,
        PH_END_CLK  = 6'b010000,
        PH_END_CS   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic                 op;
        logic                 is_data;
        logic [DATA_BITS-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic cs_n;
        logic sclk;
        logic mosi;
        logic busy_res;
        logic accepted;
    } out_item_t;

endpackage

// ===== rtl/core/spi9_seq.sv =====
// spi9_seq: phase sequencer, hold counter and shift word of the sender
// computes the line levels after each item; depends on spi9_pkg
module spi9_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  spi9_pkg::in_item_t                   item,
    input  logic [spi9_pkg::HOLD_W-1:0]          half_period,
    input  logic [spi9_pkg::HOLD_W-1:0]          end_hold,
    output spi9_pkg::out_item_t                  result
);
    import spi9_pkg::*;

    phase_t                phase_reg,      phase_next;
    logic [HOLD_W-1:0]     hold_reg,       hold_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg,    bit_idx_next;
    logic [WORD_BITS-1:0]  shift_reg,      shift_next;
    logic                  cs_reg,         cs_next;
    logic                  sclk_reg,       sclk_next;
    logic                  mosi_reg,       mosi_next;
    logic                  accepted;
    logic                  idle;
    logic [BIT_IDX_W-1:0]  bit_idx_adv;
    logic [BIT_IDX_W-1:0]  bit_pos;
    logic                  next_bit;

    assign idle = (phase_reg != PH_LEAD) && (phase_reg != PH_BIT_LOW)
               && (phase_reg != PH_BIT_HIGH) && (phase_reg != PH_END_CLK)
               && (phase_reg != PH_END_CS);

    // bit to drive at the next low half, from the index after this step
    always_comb
    begin
        bit_idx_adv = (phase_reg == PH_BIT_HIGH) ? bit_idx_reg + BIT_IDX_W'(1) : '0;
        bit_pos     = BIT_IDX_W'(DATA_BITS) - bit_idx_adv;
        next_bit    = 1'b0;
        if (bit_pos <= BIT_IDX_W'(DATA_BITS))
        begin
            next_bit = shift_reg[bit_pos];
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hold_next    = hold_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        cs_next      = cs_reg;
        sclk_next    = sclk_reg;
        mosi_next    = mosi_reg;
        accepted     = 1'b0;

        if (item.op == OP_LOAD)
        begin
            if (idle)
            begin
                shift_next   = {item.is_data, item.payload};
                bit_idx_next = '0;
                cs_next      = 1'b0;
                hold_next    = half_period;
                phase_next   = PH_LEAD;
                accepted     = 1'b1;
            end
        end
        else if (!idle)
        begin
            if (hold_reg <= HOLD_W'(1))
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        bit_idx_next = '0;
                        sclk_next    = 1'b0;
                        mosi_next    = next_bit;
                        hold_next    = half_period;
                        phase_next   = PH_BIT_LOW;
                    end
                    PH_BIT_LOW:
                    begin
                        sclk_next  = 1'b1;
                        hold_next  = half_period;
                        phase_next = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH:
                    begin
                        if (bit_idx_reg >= BIT_IDX_W'(DATA_BITS))
                        begin
                            sclk_next  = 1'b0;
                            hold_next  = end_hold;
                            phase_next = PH_END_CLK;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_adv;
                            sclk_next    = 1'b0;
                            mosi_next    = next_bit;
                            hold_next    = half_period;
                            phase_next   = PH_BIT_LOW;
                        end
                    end
                    PH_END_CLK:
                    begin
                        cs_next    = 1'b1;
                        hold_next  = end_hold;
                        phase_next = PH_END_CS;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        hold_next  = '0;
                    end
                endcase
            end
            else
            begin
                hold_next = hold_reg - HOLD_W'(1);
            end
        end
        else
        begin
            phase_next = PH_IDLE;
        end

        if (!step)
        begin
            phase_next   = phase_reg;
            hold_next    = hold_reg;
            bit_idx_next = bit_idx_reg;
            shift_next   = shift_reg;
            cs_next      = cs_reg;
            sclk_next    = sclk_reg;
            mosi_next    = mosi_reg;
        end
    end

    assign result.cs_n     = cs_next;
    assign result.sclk     = sclk_next;
    assign result.mosi     = mosi_next;
    assign result.busy_res = (phase_next != PH_IDLE);
    assign result.accepted = accepted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hold_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            cs_reg      <= 1'b1;
            sclk_reg    <= 1'b0;
            mosi_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            cs_reg      <= cs_next;
            sclk_reg    <= sclk_next;
            mosi_reg    <= mosi_next;
        end
    end

endmodule

// ===== rtl/core/three_wire_nine_bit_spi_sender.sv =====
// three_wire_nine_bit_spi_sender: top level of the 3-wire 9-bit serial sender
// holds the timing registers and the result register; uses spi9_pkg, spi9_seq
//
// Each item is a time tick or a word load and gives exactly one result: the
// chip select, clock and data levels after that item, plus busy and load-taken
// flags. One item is taken every clock cycle unless item_stall is high; the
// sequencer state and the result are computed in the cycle the item is
// accepted, and the result sits in a single output register and is shown in
// the cycle after. The input stalls only while that register is full and the
// downstream side stalls it. A load is ignored (accepted = 0) while a word is
// in flight. Timing registers are written through the cfg port: index 0 is the
// half period, index 1 the end hold, both in ticks, a value of 0 acting as 1.
module three_wire_nine_bit_spi_sender (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  spi9_pkg::in_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output spi9_pkg::out_item_t                  result,
    input  logic                                 cfg_we,
    input  logic [spi9_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spi9_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import spi9_pkg::*;

    logic [HOLD_W-1:0] half_period_reg;
    logic [HOLD_W-1:0] end_hold_reg;
    logic              valid_reg;
    out_item_t         result_reg;
    out_item_t         seq_result;
    logic              step;

    assign item_stall   = valid_reg && result_stall;
    assign step         = item_valid && !item_stall;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    spi9_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item),
        .half_period (half_period_reg),
        .end_hold    (end_hold_reg),
        .result      (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            end_hold_reg    <= END_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= cfg_data;
                REG_END_HOLD:    end_hold_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= seq_result;
        end
    end

endmodule
